FILE: design/ufmr_pkg.sv
// shared types and constants for the udp frame match and rewrite block
package ufmr_pkg;

  // frame limits and positions
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
  localparam int HDR_LEN         = 42;
  localparam int HDR_IDX_W       = $clog2(HDR_LEN);
  localparam int MAC_BYTES       = 6;
  localparam int SRC_MAC_OFS     = 6;
  localparam int IP_OFS          = 14;
  localparam int IP_PROTO_OFS    = IP_OFS + 9;
  localparam int UDP_DPORT_OFS   = IP_OFS + 22;
  localparam int UDP_LEN_OFS     = IP_OFS + 24;
  localparam int UDP_CSUM_OFS    = IP_OFS + 26;
  localparam int PAYLOAD_OFS     = 42;
  localparam int UDP_HDR_BYTES   = 8;

  localparam logic [7:0] IPV4_VER_IHL = 8'h45;
  localparam logic [7:0] PROTO_UDP    = 8'd17;

  // configuration
  localparam int CFG_DATA_W = 48;
  localparam logic [47:0] STATION_MAC_RST = 48'd274973445656822;
  localparam logic [47:0] FORWARD_MAC_RST = 48'd274973437379995;
  localparam logic [15:0] UDP_PORT_RST    = 16'd5001;

  typedef enum logic [1:0] {
    REG_STATION_MAC = 2'd0,
    REG_FORWARD_MAC = 2'd1,
    REG_UDP_PORT    = 2'd2
  } ufmr_reg_t;

  // payloads
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } ufmr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
  } ufmr_out_t;

  // controller to datapath
  typedef struct packed {
    logic                 accept;
    logic                 rd_en;
    logic [HDR_IDX_W-1:0] rd_addr;
    logic                 burst_emit;
    logic [HDR_IDX_W-1:0] burst_idx;
    logic                 burst_end;
    logic                 held_emit;
    logic                 held_end;
  } ufmr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_ready;
    logic go_burst;
    logic need_held;
    logic emit_now;
    logic last;
  } ufmr_status_t;

endpackage

FILE: design/udp_frame_match_and_rewrite_top.sv
// top level of the udp frame match and rewrite block
//
// Frames arrive one byte per request and leave one byte per request. Outside
// the header a byte is taken every cycle while the output register has room.
// When the 42nd header byte matches (station MAC, IPv4 0x45, UDP, port) the
// input stalls for a burst that replays the rewritten header from the
// 42-entry header store, one registered read per byte. After the last payload
// byte the input stalls again while the held first payload byte follows.
// Non-matching and short frames produce no output; bytes past the frame
// limit are dropped up to the frame end.
module udp_frame_match_and_rewrite_top import ufmr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  frame_valid,
  output logic                  frame_stall,
  input  ufmr_in_t              frame_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output ufmr_out_t             result_data
);

  ufmr_cmd_t    cmd;
  ufmr_status_t status;

  // sequencing
  ufmr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // storage and rewrite
  ufmr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_data   (frame_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cmd          (cmd),
    .status       (status)
  );

`ifndef SYNTH
  // a matched header stalls input on the next cycle for the burst
  a_burst_stalls: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && status.go_burst |=> frame_stall)
    else $error("input not stalled after header match");

  // at most one source loads the output register
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept && status.emit_now, cmd.burst_emit, cmd.held_emit}))
    else $error("several output sources in one cycle");

  // end of frame inside a burst only on the last header byte
  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    cmd.burst_emit && (cmd.burst_idx != HDR_IDX_W'(HDR_LEN - 1)) |-> !cmd.burst_end)
    else $error("frame end flagged before last header byte");
`endif

endmodule

FILE: design/ufmr_ctrl.sv
// controller: sequences input requests, header burst and held byte
module ufmr_ctrl import ufmr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         frame_valid,
  output logic         frame_stall,
  input  ufmr_status_t status,
  output ufmr_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_RUN,
    S_BURST,
    S_HELD
  } state_t;

  localparam logic [HDR_IDX_W-1:0] LAST_IDX = HDR_IDX_W'(HDR_LEN - 1);

  state_t               state;
  logic [HDR_IDX_W-1:0] burst_idx;
  logic                 burst_last;
  logic                 held_end;

  // input requests are taken only in run state with room at the output
  assign frame_stall = !(state == S_RUN && status.out_ready);

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.burst_idx  = burst_idx;
    cmd.burst_end  = burst_last && (burst_idx == LAST_IDX);
    cmd.held_end   = held_end;
    unique case (state)
      S_RUN: begin
        cmd.accept  = frame_valid && status.out_ready;
        cmd.rd_en   = cmd.accept && status.go_burst;
        cmd.rd_addr = '0;
      end
      S_BURST: begin
        cmd.burst_emit = status.out_ready;
        cmd.rd_en      = status.out_ready && (burst_idx != LAST_IDX);
        cmd.rd_addr    = burst_idx + 1'b1;
      end
      S_HELD: begin
        cmd.held_emit = status.out_ready;
      end
      default: begin
        cmd.accept = 1'b0;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_RUN;
      burst_idx  <= '0;
      burst_last <= 1'b0;
      held_end   <= 1'b0;
    end else begin
      unique case (state)
        S_RUN: begin
          if (cmd.accept && status.go_burst) begin
            state      <= S_BURST;
            burst_idx  <= '0;
            burst_last <= status.last;
          end else if (cmd.accept && status.need_held) begin
            state    <= S_HELD;
            held_end <= status.last;
          end
        end
        S_BURST: begin
          if (status.out_ready) begin
            if (burst_idx == LAST_IDX) begin
              state <= S_RUN;
            end else begin
              burst_idx <= burst_idx + 1'b1;
            end
          end
        end
        S_HELD: begin
          if (status.out_ready) begin
            state <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

endmodule

FILE: design/ufmr_datapath.sv
// datapath: header store, match logic, payload rewrite and output register
module ufmr_datapath import ufmr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ufmr_in_t        frame_data,
  output logic            result_valid,
  input  logic            result_stall,
  output ufmr_out_t       result_data,
  input  ufmr_cmd_t       cmd,
  output ufmr_status_t    status
);

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
    logic [5:0] sh;
    sh = {3'd5 - i, 3'b000};
    return 8'(mac >> sh);
  endfunction

  localparam logic [POS_W-1:0] POS_LAST_HDR = POS_W'(HDR_LEN - 1);
  localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(PAYLOAD_OFS);
  localparam logic [POS_W-1:0] POS_MAX_LAST = POS_W'(MAX_FRAME_BYTES - 1);

  // configuration registers
  logic [47:0] station_mac;
  logic [47:0] forward_mac;
  logic [15:0] udp_port;

  // frame state
  logic [POS_W-1:0] byte_position;
  logic             discard;
  logic             frame_selected;
  logic             match;
  logic [7:0]       port_hi;
  logic [7:0]       len_hi;
  logic [15:0]      udp_len;
  logic [7:0]       held_first_payload;
  logic [15:0]      payload_remaining;

  // header store
  logic [7:0]       hdr_mem [HDR_LEN];
  logic [7:0]       rd_data;

  logic [7:0]  in_byte;
  logic        fe;
  logic        last;
  logic        in_hdr;
  logic        payload_phase;
  logic        byte_ok;
  logic [7:0]  inv_byte;
  logic [15:0] ulen_now;
  logic [15:0] rem_init;
  logic        out_ready;
  logic        load;
  ufmr_out_t   load_data;
  logic [7:0]  burst_byte;
  logic [HDR_IDX_W-1:0] bi;

  assign in_byte  = frame_data.frame_byte;
  assign fe       = frame_data.frame_end;
  assign last     = fe || (byte_position == POS_MAX_LAST);
  assign in_hdr   = !discard && (byte_position < POS_W'(HDR_LEN));
  assign payload_phase = !discard && frame_selected && (byte_position >= POS_PAYLOAD);
  assign inv_byte = ~in_byte;
  assign ulen_now = udp_len;
  assign rem_init = (ulen_now >= 16'(UDP_HDR_BYTES)) ? ulen_now - 16'(UDP_HDR_BYTES) : '0;
  assign out_ready = !result_valid || !result_stall;

  // per-position header check
  always_comb begin
    byte_ok = 1'b1;
    if (byte_position < POS_W'(MAC_BYTES)) begin
      byte_ok = (in_byte == mac_byte(station_mac, byte_position[2:0]));
    end else if (byte_position == POS_W'(IP_OFS)) begin
      byte_ok = (in_byte == IPV4_VER_IHL);
    end else if (byte_position == POS_W'(IP_PROTO_OFS)) begin
      byte_ok = (in_byte == PROTO_UDP);
    end else if (byte_position == POS_W'(UDP_DPORT_OFS + 1)) begin
      byte_ok = ({port_hi, in_byte} == udp_port);
    end
  end

  // status toward the controller
  always_comb begin
    status.out_ready = out_ready;
    status.last      = last;
    status.go_burst  = !discard && (byte_position == POS_LAST_HDR) && match;
    status.need_held = payload_phase && (payload_remaining != '0)
                       && ((payload_remaining == 16'd1) || last);
    status.emit_now  = payload_phase
                       && ((payload_remaining == '0) || (byte_position != POS_PAYLOAD));
  end

  // header burst byte substitution
  assign bi = cmd.burst_idx;
  always_comb begin
    burst_byte = rd_data;
    if (bi < HDR_IDX_W'(MAC_BYTES)) begin
      burst_byte = mac_byte(forward_mac, bi[2:0]);
    end else if (bi < HDR_IDX_W'(SRC_MAC_OFS + MAC_BYTES)) begin
      burst_byte = mac_byte(station_mac, 3'(bi - HDR_IDX_W'(SRC_MAC_OFS)));
    end else if (bi >= HDR_IDX_W'(UDP_CSUM_OFS)) begin
      burst_byte = '0;
    end
  end

  // output source select
  always_comb begin
    load      = 1'b0;
    load_data = '0;
    if (cmd.burst_emit) begin
      load              = 1'b1;
      load_data.out_byte = burst_byte;
      load_data.out_end  = cmd.burst_end;
    end else if (cmd.held_emit) begin
      load              = 1'b1;
      load_data.out_byte = held_first_payload;
      load_data.out_end  = cmd.held_end;
    end else if (cmd.accept && status.emit_now) begin
      load              = 1'b1;
      load_data.out_byte = (payload_remaining != '0) ? inv_byte : in_byte;
      load_data.out_end  = (payload_remaining != '0) ? 1'b0 : last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= load_data;
    end
  end

  // header store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.accept && in_hdr) begin
      hdr_mem[byte_position[HDR_IDX_W-1:0]] <= in_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= hdr_mem[cmd.rd_addr];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      station_mac <= STATION_MAC_RST;
      forward_mac <= FORWARD_MAC_RST;
      udp_port    <= UDP_PORT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STATION_MAC: station_mac <= cfg_data[47:0];
        REG_FORWARD_MAC: forward_mac <= cfg_data[47:0];
        REG_UDP_PORT:    udp_port    <= cfg_data[15:0];
        default:         udp_port    <= udp_port;
      endcase
    end
  end

  // header field capture, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept && in_hdr) begin
      if (byte_position == POS_W'(UDP_DPORT_OFS)) begin
        port_hi <= in_byte;
      end
      if (byte_position == POS_W'(UDP_LEN_OFS)) begin
        len_hi <= in_byte;
      end
      if (byte_position == POS_W'(UDP_LEN_OFS + 1)) begin
        udp_len[7:0] <= in_byte;
      end
      udp_len[15:8] <= len_hi;
      if (byte_position == '0) begin
        match <= byte_ok;
      end else begin
        match <= match && byte_ok;
      end
    end
  end

  // held first payload byte
  always_ff @(posedge clk) begin
    if (rst) begin
      held_first_payload <= '0;
    end else if (cmd.accept && payload_phase && (payload_remaining != '0)
                 && (byte_position == POS_PAYLOAD)) begin
      held_first_payload <= inv_byte;
    end
  end

  // frame position, selection and payload count
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      discard           <= 1'b0;
      frame_selected    <= 1'b0;
      payload_remaining <= '0;
    end else if (cmd.accept) begin
      if (discard) begin
        if (fe) begin
          discard       <= 1'b0;
          byte_position <= '0;
        end
      end else begin
        if (status.go_burst) begin
          frame_selected    <= 1'b1;
          payload_remaining <= rem_init;
        end else if (payload_phase && (payload_remaining != '0)) begin
          payload_remaining <= payload_remaining - 16'd1;
        end
        if (fe) begin
          byte_position     <= '0;
          frame_selected    <= 1'b0;
          payload_remaining <= '0;
        end else if (byte_position == POS_MAX_LAST) begin
          discard           <= 1'b1;
          frame_selected    <= 1'b0;
          payload_remaining <= '0;
        end else begin
          byte_position <= byte_position + 1'b1;
        end
      end
    end
  end

endmodule

FILE: dv/udp_frame_match_and_rewrite_top_tb.sv
// testbench for the udp frame match and rewrite block with directed and random frames
module udp_frame_match_and_rewrite_top_tb;
  import ufmr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE      = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 100;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  frame_valid;
  logic                  frame_stall;
  ufmr_in_t              frame_data;
  logic                  result_valid;
  logic                  result_stall;
  ufmr_out_t             result_data;

  udp_frame_match_and_rewrite_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_data   (frame_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  // rewrite predictor state and its copy of the registers
  logic [47:0] model_station_mac = STATION_MAC_RST;
  logic [47:0] model_forward_mac = FORWARD_MAC_RST;
  logic [15:0] model_udp_port    = UDP_PORT_RST;
  logic [7:0]  hdr_copy [HDR_LEN];
  int          frame_pos    = 0;
  logic        fwd_active   = 1'b0;
  logic [7:0]  held_byte    = '0;
  int          payload_left = 0;

  // bytes still owed by the block, oldest first
  ufmr_out_t   owed_bytes [$];
  logic [7:0]  frame_buf [$];

  int   n_errors      = 0;
  int   n_cycles      = 0;
  int   frames_sent   = 0;
  int   bytes_sent    = 0;
  int   bytes_checked = 0;
  int   n_settings    = 1;
  logic quiet_run     = 1'b0;
  logic hold_req      = 1'b0;
  int   hold_left     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", n_cycles, owed_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on demand
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (quiet_run) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < 8);
      end
    end
  end

  // compare each output byte with the oldest owed byte
  always @(posedge clk) begin
    ufmr_out_t want;
    if (!rst && result_valid && !result_stall) begin
      bytes_checked++;
      if (owed_bytes.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $error("unexpected output byte %02h end %0b", result_data.out_byte, result_data.out_end);
      end else begin
        want = owed_bytes.pop_front();
        if (result_data.out_byte !== want.out_byte) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $error("out_byte: expected %02h, got %02h", want.out_byte, result_data.out_byte);
        end
        if (result_data.out_end !== want.out_end) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $error("out_end: expected %0b, got %0b", want.out_end, result_data.out_end);
        end
      end
    end
  end

  function automatic void owe_byte(input logic [7:0] b, input logic e);
    ufmr_out_t r;
    r.out_byte = b;
    r.out_end  = e;
    owed_bytes.push_back(r);
  endfunction

  // advance the rewrite predictor by one accepted input byte
  function automatic void predict_rewrite(input logic [7:0] b, input logic e);
    logic        is_last;
    logic        hit;
    logic [15:0] ulen;
    if (frame_pos >= MAX_FRAME_BYTES) begin
      // discarding the tail of an overlong frame
      if (e) frame_pos = 0;
      return;
    end
    is_last = e || (frame_pos == MAX_FRAME_BYTES - 1);

    if (frame_pos < HDR_LEN) begin
      hdr_copy[frame_pos] = b;
      if (frame_pos == HDR_LEN - 1) begin
        hit = 1'b1;
        for (int i = 0; i < MAC_BYTES; i++)
          if (hdr_copy[i] != model_station_mac[8*(5-i) +: 8]) hit = 1'b0;
        if (hdr_copy[IP_OFS] != IPV4_VER_IHL) hit = 1'b0;
        if (hdr_copy[IP_PROTO_OFS] != PROTO_UDP) hit = 1'b0;
        if ({hdr_copy[UDP_DPORT_OFS], hdr_copy[UDP_DPORT_OFS+1]} != model_udp_port) hit = 1'b0;
        if (hit) begin
          // header burst with rewritten macs and cleared checksum
          fwd_active = 1'b1;
          for (int i = 0; i < MAC_BYTES; i++) begin
            hdr_copy[i]               = model_forward_mac[8*(5-i) +: 8];
            hdr_copy[SRC_MAC_OFS + i] = model_station_mac[8*(5-i) +: 8];
          end
          hdr_copy[UDP_CSUM_OFS]     = '0;
          hdr_copy[UDP_CSUM_OFS + 1] = '0;
          ulen = {hdr_copy[UDP_LEN_OFS], hdr_copy[UDP_LEN_OFS+1]};
          payload_left = (ulen >= UDP_HDR_BYTES) ? int'(ulen) - UDP_HDR_BYTES : 0;
          for (int i = 0; i < HDR_LEN; i++)
            owe_byte(hdr_copy[i], (i == HDR_LEN - 1) ? is_last : 1'b0);
        end
      end
    end else if (fwd_active) begin
      if (payload_left > 0) begin
        // inverted payload, first byte held back to the end
        if (frame_pos == PAYLOAD_OFS) held_byte = ~b;
        else owe_byte(~b, 1'b0);
        payload_left--;
        if (payload_left == 0 || is_last) owe_byte(held_byte, is_last);
      end else begin
        owe_byte(b, is_last);
      end
    end

    if (e) begin
      frame_pos    = 0;
      fwd_active   = 1'b0;
      payload_left = 0;
    end else if (frame_pos == MAX_FRAME_BYTES - 1) begin
      frame_pos    = MAX_FRAME_BYTES;
      fwd_active   = 1'b0;
      payload_left = 0;
    end else begin
      frame_pos++;
    end
  endfunction

  // send one request; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic e);
    if (!quiet_run && $urandom_range(0, 99) < 8) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame_data  <= ufmr_in_t'({b, e});
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    predict_rewrite(b, e);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++)
      send_byte(frame_buf[i], i == n - 1);
    frames_sent++;
  endtask

  // random frame with the given header fields and bytes after the header
  task automatic build_frame(input logic [47:0] dst, input logic [7:0] ver,
                             input logic [7:0] proto, input logic [15:0] dport,
                             input logic [15:0] ulen, input int tail);
    frame_buf.delete();
    for (int i = 0; i < HDR_LEN + tail; i++)
      frame_buf.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < MAC_BYTES; i++)
      frame_buf[i] = dst[8*(5-i) +: 8];
    frame_buf[12]              = 8'h08;
    frame_buf[13]              = 8'h00;
    frame_buf[IP_OFS]          = ver;
    frame_buf[IP_PROTO_OFS]    = proto;
    frame_buf[UDP_DPORT_OFS]   = dport[15:8];
    frame_buf[UDP_DPORT_OFS+1] = dport[7:0];
    frame_buf[UDP_LEN_OFS]     = ulen[15:8];
    frame_buf[UDP_LEN_OFS+1]   = ulen[7:0];
  endtask

  // matching frame with the given udp length and tail bytes after the header
  task automatic good_frame(input int ulen, input int tail);
    build_frame(model_station_mac, IPV4_VER_IHL, PROTO_UDP, model_udp_port, 16'(ulen), tail);
  endtask

  // idle the sender until every owed byte is out, then let the block settle
  task automatic wait_drained();
    frame_valid <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input ufmr_reg_t idx, input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STATION_MAC: model_station_mac = val;
      REG_FORWARD_MAC: model_forward_mac = val;
      REG_UDP_PORT:    model_udp_port    = val[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [47:0] st, input logic [47:0] fw, input logic [15:0] port);
    wait_drained();
    write_reg(REG_STATION_MAC, st);
    write_reg(REG_FORWARD_MAC, fw);
    write_reg(REG_UDP_PORT, {32'd0, port});
    n_settings++;
  endtask

  // mostly matching frames, some broken, mismatched or garbage
  task automatic random_frame();
    int          kind;
    int          pl;
    int          tail;
    int          n;
    int          bit_idx;
    logic [47:0] dst;
    logic [7:0]  ver;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [15:0] ulen;
    kind  = $urandom_range(0, 99);
    dst   = model_station_mac;
    ver   = IPV4_VER_IHL;
    proto = PROTO_UDP;
    dport = model_udp_port;
    pl    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 160);
    ulen  = 16'(pl + UDP_HDR_BYTES);
    tail  = pl;
    n     = $urandom_range(0, 99);
    if (n >= 60 && n < 75) tail = pl + $urandom_range(1, 6);
    else if (n >= 75 && n < 85) ulen = 16'($urandom_range(0, UDP_HDR_BYTES - 1));
    else if (n >= 85) ulen = 16'(pl + UDP_HDR_BYTES + $urandom_range(1, 300));
    if (kind >= 75 && kind < 95) begin
      case ($urandom_range(0, 3))
        0: begin
          bit_idx = $urandom_range(0, 47);
          dst[bit_idx] = ~dst[bit_idx];
        end
        1: begin
          ver = 8'($urandom_range(0, 255));
          if (ver == IPV4_VER_IHL) ver = 8'h46;
        end
        2: begin
          proto = 8'($urandom_range(0, 255));
          if (proto == PROTO_UDP) proto = 8'd6;
        end
        default: dport = dport ^ 16'($urandom_range(1, 16'hFFFF));
      endcase
    end
    build_frame(dst, ver, proto, dport, ulen, tail);
    n = frame_buf.size();
    if (kind >= 70 && kind < 75) n = $urandom_range(1, HDR_LEN - 1);
    if (kind >= 95) begin
      frame_buf.delete();
      n = $urandom_range(1, 80);
      for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    end
    send_frame(n);
  endtask

  // forwarding with the reset registers: rotation, pass-through, short udp length, cut payload
  task automatic test_basic_forwarding();
    good_frame(UDP_HDR_BYTES + 4, 4);
    frame_buf[PAYLOAD_OFS]     = 8'h00;
    frame_buf[PAYLOAD_OFS + 1] = 8'hFF;
    send_frame(frame_buf.size());
    good_frame(UDP_HDR_BYTES + 1, 1);
    send_frame(frame_buf.size());
    good_frame(UDP_HDR_BYTES, 3);
    send_frame(frame_buf.size());
    good_frame(5, 4);
    send_frame(frame_buf.size());
    // frame ends on the last header byte
    good_frame(0, 0);
    send_frame(frame_buf.size());
    good_frame(UDP_HDR_BYTES + 20, 6);
    send_frame(frame_buf.size());
    good_frame(UDP_HDR_BYTES + 3, 8);
    send_frame(frame_buf.size());
  endtask

  // frames that must leave no output
  task automatic test_drop_cases();
    good_frame(UDP_HDR_BYTES + 4, 4);
    send_frame(20);
    send_frame(1);
    send_frame(HDR_LEN - 1);
    build_frame(model_station_mac ^ 48'h8000_0000_0000, IPV4_VER_IHL, PROTO_UDP,
                model_udp_port, 16'(UDP_HDR_BYTES + 2), 2);
    send_frame(frame_buf.size());
    build_frame(model_station_mac ^ 48'h1, IPV4_VER_IHL, PROTO_UDP,
                model_udp_port, 16'(UDP_HDR_BYTES + 2), 2);
    send_frame(frame_buf.size());
    build_frame(model_station_mac, 8'h46, PROTO_UDP, model_udp_port,
                16'(UDP_HDR_BYTES + 2), 2);
    send_frame(frame_buf.size());
    build_frame(model_station_mac, IPV4_VER_IHL, 8'd6, model_udp_port,
                16'(UDP_HDR_BYTES + 2), 2);
    send_frame(frame_buf.size());
    build_frame(model_station_mac, IPV4_VER_IHL, PROTO_UDP, ~model_udp_port,
                16'(UDP_HDR_BYTES + 2), 2);
    send_frame(frame_buf.size());
    // a good frame right after the drops
    good_frame(UDP_HDR_BYTES + 2, 2);
    send_frame(frame_buf.size());
  endtask

  // frames past the length limit: payload cut at the limit, then trailer cut at the limit
  task automatic test_overlong_frames();
    good_frame(65535, 2100 - HDR_LEN);
    send_frame(frame_buf.size());
    good_frame(UDP_HDR_BYTES + 10, 2100 - HDR_LEN);
    send_frame(frame_buf.size());
    build_frame(model_station_mac, 8'h00, PROTO_UDP, model_udp_port, 16'hFFFF, 2060 - HDR_LEN);
    send_frame(frame_buf.size());
    good_frame(UDP_HDR_BYTES + 3, 3);
    send_frame(frame_buf.size());
  endtask

  // long receiver hold-off while the sender keeps pushing, then a full sender pause
  task automatic test_backpressure();
    hold_req = 1'b1;
    good_frame(UDP_HDR_BYTES + 300, 300);
    send_frame(frame_buf.size());
    good_frame(UDP_HDR_BYTES + 5, 5);
    send_frame(frame_buf.size());
    wait_drained();
    good_frame(UDP_HDR_BYTES + 7, 9);
    send_frame(frame_buf.size());
  endtask

  task automatic test_random_traffic(input int n_frames, input logic calm);
    quiet_run = calm;
    for (int i = 0; i < n_frames; i++) random_frame();
    quiet_run = 1'b0;
  endtask

  // all-zero and all-one register settings
  task automatic test_config_extremes();
    set_config(48'h0, 48'h0, 16'h0);
    test_random_traffic(60, 1'b0);
    set_config(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    test_random_traffic(60, 1'b0);
  endtask

  // random register settings, one phase without any idling
  task automatic test_random_settings();
    for (int p = 0; p < 3; p++) begin
      set_config({16'($urandom_range(0, 16'hFFFF)), 32'($urandom())},
                 {16'($urandom_range(0, 16'hFFFF)), 32'($urandom())},
                 16'($urandom_range(0, 16'hFFFF)));
      test_random_traffic(60, p == 1);
    end
  endtask

  // main sequence
  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_STATION_MAC;
    cfg_data    = '0;
    frame_valid = 1'b0;
    frame_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_forwarding();
    test_drop_cases();
    test_overlong_frames();
    test_backpressure();
    test_random_traffic(120, 1'b0);
    test_config_extremes();
    test_random_settings();

    wait_drained();
    $display("sent %0d frames (%0d bytes) over %0d register settings",
             frames_sent, bytes_sent, n_settings);
    $display("checked %0d forwarded bytes, %0d mismatches", bytes_checked, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
